@@ rtl/core/mcpp_pkg.sv @@
// Shared types and constants for the MQTT CONNECT/PUBLISH header parser.
// Holds the request and response transaction structs, field tags and flag positions.
// Depends on nothing.
`default_nettype none

package mcpp_pkg;

   localparam int unsigned MAX_LENGTH_BYTES_DEFAULT = 4;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [4:0]  field_tag;
      logic [27:0] field_value;
      logic        frame_last;
      logic        frame_error;
   } rsp_type;

   // Field tags reported with each byte.
   localparam logic [4:0] TAG_NONE       = 5'd0;
   localparam logic [4:0] TAG_TYPE       = 5'd1;
   localparam logic [4:0] TAG_LENGTH     = 5'd2;
   localparam logic [4:0] TAG_PROTO_LEN  = 5'd3;
   localparam logic [4:0] TAG_LEVEL      = 5'd5;
   localparam logic [4:0] TAG_FLAGS      = 5'd6;
   localparam logic [4:0] TAG_KEEP_ALIVE = 5'd7;
   localparam logic [4:0] TAG_CLIENT_LEN = 5'd8;
   localparam logic [4:0] TAG_WTOPIC_LEN = 5'd10;
   localparam logic [4:0] TAG_WMSG_LEN   = 5'd12;
   localparam logic [4:0] TAG_USER_LEN   = 5'd14;
   localparam logic [4:0] TAG_PASS_LEN   = 5'd16;
   localparam logic [4:0] TAG_TOPIC_LEN  = 5'd18;
   localparam logic [4:0] TAG_PACKET_ID  = 5'd20;
   localparam logic [4:0] TAG_PAYLOAD    = 5'd21;
   localparam logic [4:0] TAG_BODY       = 5'd22;

   // Control packet types that get a structured walk.
   localparam logic [3:0] KIND_CONNECT = 4'd1;
   localparam logic [3:0] KIND_PUBLISH = 4'd3;

   // Bit positions in the CONNECT flags byte.
   localparam int unsigned CFLAG_WILL     = 2;
   localparam int unsigned CFLAG_PASSWORD = 6;
   localparam int unsigned CFLAG_USER     = 7;

   // Length-prefixed strings in the order they can appear.
   typedef enum logic [2:0] {
      STR_PROTO,
      STR_CLIENT,
      STR_WILL_TOPIC,
      STR_WILL_MSG,
      STR_USER,
      STR_PASS,
      STR_TOPIC
   } str_sel_type;

   // Tag of a string's length field; its data bytes use the next tag up.
   function automatic logic [4:0] str_len_tag(input str_sel_type sel);
      logic [4:0] tag;
      case (sel)
         STR_PROTO:      tag = TAG_PROTO_LEN;
         STR_CLIENT:     tag = TAG_CLIENT_LEN;
         STR_WILL_TOPIC: tag = TAG_WTOPIC_LEN;
         STR_WILL_MSG:   tag = TAG_WMSG_LEN;
         STR_USER:       tag = TAG_USER_LEN;
         STR_PASS:       tag = TAG_PASS_LEN;
         STR_TOPIC:      tag = TAG_TOPIC_LEN;
         default:        tag = TAG_BODY;
      endcase
      return tag;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/mcpp_decoder.sv @@
// Per-byte parse state and decode logic for the MQTT header parser.
// Holds the frame walk state and produces one response for each stepped byte.
// Depends on mcpp_pkg.
`default_nettype none

module mcpp_decoder #(
   parameter int unsigned MAX_LENGTH_BYTES = mcpp_pkg::MAX_LENGTH_BYTES_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step_valid,
   input  wire mcpp_pkg::req_type step_item,
   output mcpp_pkg::rsp_type     step_result
);

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_VARINT,
      PH_LEVEL,
      PH_FLAGS,
      PH_KA_H,
      PH_KA_L,
      PH_STR_H,
      PH_STR_L,
      PH_STR_DATA,
      PH_PI_H,
      PH_PI_L,
      PH_PAY,
      PH_BODY
   } phase_type;

   typedef struct packed {
      phase_type             phase;
      mcpp_pkg::str_sel_type sel;
   } next_type;

   phase_type             phase_ff, phase_in;
   mcpp_pkg::str_sel_type sel_ff, sel_in;
   logic [3:0]            kind_ff, kind_in;
   logic [1:0]            qos_ff, qos_in;
   logic [7:0]            flags_ff, flags_in;
   logic [27:0]           acc_ff, acc_in;
   logic [1:0]            vidx_ff, vidx_in;
   logic [15:0]           field_left_ff, field_left_in;
   logic [7:0]            high_ff, high_in;
   logic [27:0]           frame_left_ff, frame_left_in;

   logic [7:0]            byte_v;
   logic [27:0]           group;
   logic [27:0]           acc_sum;
   logic                  varint_done;
   logic [27:0]           frame_dec;
   logic [15:0]           str_len;
   logic                  str_over;
   logic [15:0]           field_use;
   logic [15:0]           field_dec;
   next_type              nxt;
   mcpp_pkg::rsp_type     res;

   function automatic next_type after_user(input logic [7:0] flags);
      next_type n;
      n.sel   = mcpp_pkg::STR_PASS;
      n.phase = flags[mcpp_pkg::CFLAG_PASSWORD] ? PH_STR_H : PH_BODY;
      return n;
   endfunction

   function automatic next_type after_will(input logic [7:0] flags);
      next_type n;
      if (flags[mcpp_pkg::CFLAG_USER]) begin
         n.sel   = mcpp_pkg::STR_USER;
         n.phase = PH_STR_H;
      end else begin
         n = after_user(flags);
      end
      return n;
   endfunction

   // Where the walk goes once a string (length and data) is finished.
   function automatic next_type next_after(input mcpp_pkg::str_sel_type sel,
                                           input logic [7:0] flags,
                                           input logic [1:0] qos);
      next_type n;
      n.sel   = sel;
      n.phase = PH_BODY;
      case (sel)
         mcpp_pkg::STR_PROTO: begin
            n.phase = PH_LEVEL;
         end
         mcpp_pkg::STR_CLIENT: begin
            if (flags[mcpp_pkg::CFLAG_WILL]) begin
               n.sel   = mcpp_pkg::STR_WILL_TOPIC;
               n.phase = PH_STR_H;
            end else begin
               n = after_will(flags);
            end
         end
         mcpp_pkg::STR_WILL_TOPIC: begin
            n.sel   = mcpp_pkg::STR_WILL_MSG;
            n.phase = PH_STR_H;
         end
         mcpp_pkg::STR_WILL_MSG: begin
            n = after_will(flags);
         end
         mcpp_pkg::STR_USER: begin
            n = after_user(flags);
         end
         mcpp_pkg::STR_TOPIC: begin
            n.phase = (qos != 2'd0) ? PH_PI_H : PH_PAY;
         end
         default: begin
            n.phase = PH_BODY;
         end
      endcase
      return n;
   endfunction

   assign byte_v = step_item.frame_byte;

   // Place the 7-bit group of this length byte; groups never overlap.
   always_comb begin
      case (vidx_ff)
         2'd0:    group = {21'd0, byte_v[6:0]};
         2'd1:    group = {14'd0, byte_v[6:0], 7'd0};
         2'd2:    group = {7'd0, byte_v[6:0], 14'd0};
         2'd3:    group = {byte_v[6:0], 21'd0};
         default: group = '0;
      endcase
   end

   assign acc_sum     = acc_ff + group;
   assign varint_done = !byte_v[7]
                        || (({1'b0, vidx_ff} + 3'd1) >= 3'(MAX_LENGTH_BYTES))
                        || (vidx_ff == 2'd3);
   assign frame_dec   = (frame_left_ff != '0) ? frame_left_ff - 28'd1 : '0;
   assign str_len     = {high_ff, byte_v};
   assign str_over    = {12'd0, str_len} > frame_dec;
   assign field_use   = str_over ? frame_dec[15:0] : str_len;
   assign field_dec   = (field_left_ff != '0) ? field_left_ff - 16'd1 : '0;
   assign nxt         = next_after(sel_ff, flags_ff, qos_ff);

   always_comb begin
      phase_in      = phase_ff;
      sel_in        = sel_ff;
      kind_in       = kind_ff;
      qos_in        = qos_ff;
      flags_in      = flags_ff;
      acc_in        = acc_ff;
      vidx_in       = vidx_ff;
      field_left_in = field_left_ff;
      high_in       = high_ff;
      frame_left_in = frame_left_ff;
      res           = '0;

      if (step_item.frame_start) begin
         // A control byte always opens a new frame, abandoning any old one.
         kind_in         = byte_v[7:4];
         qos_in          = byte_v[2:1];
         flags_in        = '0;
         acc_in          = '0;
         vidx_in         = '0;
         field_left_in   = '0;
         high_in         = '0;
         frame_left_in   = '0;
         phase_in        = PH_VARINT;
         res.field_tag   = mcpp_pkg::TAG_TYPE;
         res.field_value = {24'd0, byte_v[7:4]};
      end else if (phase_ff == PH_IDLE) begin
         res.frame_error = 1'b1;
      end else if (phase_ff == PH_VARINT) begin
         acc_in = acc_sum;
         if (varint_done) begin
            res.field_tag   = mcpp_pkg::TAG_LENGTH;
            res.field_value = acc_sum;
            frame_left_in   = acc_sum;
            if (acc_sum == '0) begin
               res.frame_last = 1'b1;
               phase_in       = PH_IDLE;
            end else if (kind_ff == mcpp_pkg::KIND_CONNECT) begin
               phase_in = PH_STR_H;
               sel_in   = mcpp_pkg::STR_PROTO;
            end else if (kind_ff == mcpp_pkg::KIND_PUBLISH) begin
               phase_in = PH_STR_H;
               sel_in   = mcpp_pkg::STR_TOPIC;
            end else begin
               phase_in = PH_BODY;
            end
         end else begin
            vidx_in = vidx_ff + 2'd1;
         end
      end else begin
         frame_left_in = frame_dec;
         case (phase_ff)
            PH_LEVEL: begin
               res.field_tag   = mcpp_pkg::TAG_LEVEL;
               res.field_value = {20'd0, byte_v};
               phase_in        = PH_FLAGS;
            end
            PH_FLAGS: begin
               res.field_tag   = mcpp_pkg::TAG_FLAGS;
               res.field_value = {20'd0, byte_v};
               flags_in        = byte_v;
               phase_in        = PH_KA_H;
            end
            PH_KA_H: begin
               high_in  = byte_v;
               phase_in = PH_KA_L;
            end
            PH_KA_L: begin
               res.field_tag   = mcpp_pkg::TAG_KEEP_ALIVE;
               res.field_value = {12'd0, str_len};
               phase_in        = PH_STR_H;
               sel_in          = mcpp_pkg::STR_CLIENT;
            end
            PH_PI_H: begin
               high_in  = byte_v;
               phase_in = PH_PI_L;
            end
            PH_PI_L: begin
               res.field_tag   = mcpp_pkg::TAG_PACKET_ID;
               res.field_value = {12'd0, str_len};
               phase_in        = PH_PAY;
            end
            PH_PAY: begin
               res.field_tag   = mcpp_pkg::TAG_PAYLOAD;
               res.field_value = {20'd0, byte_v};
            end
            PH_STR_H: begin
               high_in  = byte_v;
               phase_in = PH_STR_L;
            end
            PH_STR_L: begin
               // An overlong string is reported as sent, then clipped to the frame.
               res.field_tag   = mcpp_pkg::str_len_tag(sel_ff);
               res.field_value = {12'd0, str_len};
               res.frame_error = str_over;
               field_left_in   = field_use;
               if (field_use != '0) begin
                  phase_in = PH_STR_DATA;
               end else begin
                  phase_in = nxt.phase;
                  sel_in   = nxt.sel;
               end
            end
            PH_STR_DATA: begin
               res.field_tag   = mcpp_pkg::str_len_tag(sel_ff) + 5'd1;
               res.field_value = {20'd0, byte_v};
               field_left_in   = field_dec;
               if (field_dec == '0) begin
                  phase_in = nxt.phase;
                  sel_in   = nxt.sel;
               end
            end
            default: begin
               res.field_tag   = mcpp_pkg::TAG_BODY;
               res.field_value = {20'd0, byte_v};
               phase_in        = PH_BODY;
            end
         endcase
         if (frame_dec == '0) begin
            res.frame_last = 1'b1;
            phase_in       = PH_IDLE;
         end
      end
   end

   assign step_result = res;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         sel_ff        <= mcpp_pkg::STR_PROTO;
         kind_ff       <= '0;
         qos_ff        <= '0;
         flags_ff      <= '0;
         acc_ff        <= '0;
         vidx_ff       <= '0;
         field_left_ff <= '0;
         high_ff       <= '0;
         frame_left_ff <= '0;
      end else if (step_valid) begin
         phase_ff      <= phase_in;
         sel_ff        <= sel_in;
         kind_ff       <= kind_in;
         qos_ff        <= qos_in;
         flags_ff      <= flags_in;
         acc_ff        <= acc_in;
         vidx_ff       <= vidx_in;
         field_left_ff <= field_left_in;
         high_ff       <= high_in;
         frame_left_ff <= frame_left_in;
      end
   end

   // String data is only walked while bytes of it remain.
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_STR_DATA |-> field_left_ff != '0)
      else $error("string data phase with no bytes left");

   // The byte that ends a frame leaves the parser waiting for a new frame.
   assert property (@(posedge clock) disable iff (reset)
      step_valid && step_result.frame_last |=> phase_ff == PH_IDLE)
      else $error("parser not idle after last byte of frame");

   // An untagged error only comes from a stray byte outside any frame.
   assert property (@(posedge clock) disable iff (reset)
      step_valid && step_result.frame_error && step_result.field_tag == mcpp_pkg::TAG_NONE
      |-> phase_ff == PH_IDLE && !step_item.frame_start)
      else $error("untagged error while inside a frame");

endmodule

`default_nettype wire

@@ rtl/core/mqtt_connect_publish_parser.sv @@
// Top level of the MQTT CONNECT/PUBLISH header parser.
// Input register, per-byte decoder and output register; depends on mcpp_pkg and mcpp_decoder.
`default_nettype none

// The parser takes one MQTT frame byte per transaction, with frame_start set on the
// control byte, and returns exactly one response per byte: a field tag, the decoded
// value, a last-of-frame mark and an error mark. It sustains one byte per clock cycle
// while the response side does not stall; a byte is loaded into the input register
// when its request is accepted, and its response into the output register when it is
// decoded. The rate is set by the parse state update, which is combinational and covers
// a whole byte. Stall on the response side backs up through both registers, so up to
// two bytes are held in flight.

module mqtt_connect_publish_parser #(
   parameter int unsigned MAX_LENGTH_BYTES = mcpp_pkg::MAX_LENGTH_BYTES_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire mcpp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output mcpp_pkg::rsp_type rsp_data
);

   logic              in_valid_ff, in_valid_in;
   mcpp_pkg::req_type in_data_ff;
   logic              out_valid_ff, out_valid_in;
   mcpp_pkg::rsp_type out_data_ff;
   logic              req_take;
   logic              step;
   mcpp_pkg::rsp_type step_result;

   // The held byte is decoded when the output register is free or being emptied.
   assign step      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !step;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !step);
   assign out_valid_in = step || (out_valid_ff && rsp_stall);

   mcpp_decoder #(
      .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
   ) u_decoder (
      .clock      (clock),
      .reset      (reset),
      .step_valid (step),
      .step_item  (in_data_ff),
      .step_result(step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (step) begin
         out_data_ff <= step_result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // A byte blocked in the input register stays there unchanged.
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !step |=> in_valid_ff && $stable(in_data_ff))
      else $error("input register lost a blocked byte");

   // Every accepted request lands in the input register.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> in_valid_ff)
      else $error("accepted request not captured");

   // Every decoded byte shows up as a response on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid)
      else $error("decoded byte produced no response");

endmodule

`default_nettype wire
